FILE: rtl/nbcs_pkg.sv
// Shared constants, types and helper functions for the NV12 bilinear crop scaler.
// No dependencies; every other file refers to this package by scoped names.
package nbcs_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

   localparam int CFG_W      = 9;   // register width
   localparam int CSR_IDX_W  = 2;
   localparam int LOAD_AW    = 17;  // load_addr field width
   localparam int COORD_W    = 8;
   localparam int PIX_W      = 8;
   localparam int FRAC_W     = 16;

   localparam int FRAME_BYTES = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
   localparam int MEM_AW      = $clog2(FRAME_BYTES);
   localparam int ADDR_W      = MEM_AW + 1;

   localparam int SIZE_W  = $clog2(MAX_DIM + 1);
   localparam int INV_W   = SIZE_W + 15;
   localparam int PX_W    = COORD_W + INV_W;
   localparam int BASE_W  = PX_W - FRAC_W;
   localparam int PCT     = 100;
   localparam int RATIO_W = $clog2(MAX_DIM * PCT / 2 + 1);
   localparam int DIV_W   = SIZE_W + FRAC_W;
   localparam int DVS_W   = (SIZE_W > 7) ? SIZE_W : 7;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

   // request actions
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_LUMA   = 2'd1;
   localparam logic [1:0] ACT_CHROMA = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // quad tags through the blend pipe
   localparam logic [1:0] TAG_LUMA = 2'd0;
   localparam logic [1:0] TAG_U    = 2'd1;
   localparam logic [1:0] TAG_V    = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] sw;
      logic [SIZE_W-1:0] sh;
      logic [SIZE_W-1:0] left;
      logic [SIZE_W-1:0] top;
      logic [INV_W-1:0]  invx;
      logic [INV_W-1:0]  invy;
      logic [ADDR_W-1:0] cbase;
      logic              ready;
   } geom_type;

   // clear bit 0, saturate to [2, maxv]
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
      logic [31:0] e;
      e = 32'(v) & ~32'd1;
      if (e < 32'd2) e = 32'd2;
      if (e > 32'(maxv)) e = 32'(maxv) & ~32'd1;
      return SIZE_W'(e);
   endfunction

   // keep base so that base+1 stays inside the plane
   function automatic logic [SIZE_W-1:0] clamp_base(input logic [BASE_W-1:0] b,
                                                    input logic [SIZE_W-1:0] size);
      logic [BASE_W:0] b1;
      logic [SIZE_W-1:0] r;
      b1 = {1'b0, b} + (BASE_W+1)'(1);
      if (b1 >= (BASE_W+1)'(size)) begin
         r = (size >= SIZE_W'(2)) ? size - SIZE_W'(2) : '0;
      end else begin
         r = SIZE_W'(b);
      end
      return r;
   endfunction

endpackage

FILE: rtl/nbcs_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on nbcs_pkg for widths.
module nbcs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [nbcs_pkg::DIV_W-1:0]  numer,
   input  logic [nbcs_pkg::DVS_W-1:0]  denom,
   output logic                        done,
   output logic [nbcs_pkg::DIV_W-1:0]  quot
);

   logic [nbcs_pkg::DVS_W:0]    rem_ff, rem_in;
   logic [nbcs_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [nbcs_pkg::DVS_W-1:0]  den_ff;
   logic [nbcs_pkg::DCNT_W-1:0] cnt_ff;
   logic                        run_ff, done_ff;
   logic [nbcs_pkg::DVS_W:0]    trial;

   always_comb begin
      trial = {rem_ff[nbcs_pkg::DVS_W-1:0], quo_ff[nbcs_pkg::DIV_W-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = trial - {1'b0, den_ff};
         quo_in = {quo_ff[nbcs_pkg::DIV_W-2:0], 1'b1};
      end else begin
         rem_in = trial;
         quo_in = {quo_ff[nbcs_pkg::DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !go && run_ff && (cnt_ff == nbcs_pkg::DCNT_W'(1));
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= nbcs_pkg::DCNT_W'(nbcs_pkg::DIV_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - nbcs_pkg::DCNT_W'(1);
            if (cnt_ff == nbcs_pkg::DCNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: rtl/nbcs_geom.sv
// Size registers and crop/step geometry, recomputed after reset and each write.
// Depends on nbcs_pkg and nbcs_div.
module nbcs_geom (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [nbcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nbcs_pkg::CFG_W-1:0]       csr_wdata,
   output nbcs_pkg::geom_type               geom
);

   localparam logic [1:0] G_IDLE   = 2'd0;
   localparam logic [1:0] G_LAUNCH = 2'd1;
   localparam logic [1:0] G_WAIT   = 2'd2;
   localparam logic [1:0] G_BASE   = 2'd3;

   logic [nbcs_pkg::CFG_W-1:0]   src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [1:0]                   state_ff;
   logic [2:0]                   step_ff;
   logic [nbcs_pkg::RATIO_W-1:0] qs_ff, qd_ff, rw_ff, rh_ff;
   logic [nbcs_pkg::SIZE_W-1:0]  cwc_ff, chc_ff;
   logic [nbcs_pkg::INV_W-1:0]   invx_ff, invy_ff;
   logic [nbcs_pkg::ADDR_W-1:0]  cbase_ff;

   logic [nbcs_pkg::SIZE_W-1:0]  sw, sh, dw, dh, cw, chh, left, top;
   logic [nbcs_pkg::RATIO_W-1:0] ratio;
   logic                         differ;
   logic [nbcs_pkg::DIV_W-1:0]   numer, quot;
   logic [nbcs_pkg::DVS_W-1:0]   denom;
   logic                         div_done;

   assign sw = nbcs_pkg::eff_size(src_w_ff, nbcs_pkg::MAX_WIDTH);
   assign sh = nbcs_pkg::eff_size(src_h_ff, nbcs_pkg::MAX_HEIGHT);
   assign dw = nbcs_pkg::eff_size(dst_w_ff, nbcs_pkg::MAX_WIDTH);
   assign dh = nbcs_pkg::eff_size(dst_h_ff, nbcs_pkg::MAX_HEIGHT);

   assign differ = (qs_ff != qd_ff);
   assign ratio  = (rw_ff >= rh_ff) ? rh_ff : rw_ff;
   assign cw     = differ ? cwc_ff : sw;
   assign chh    = differ ? chc_ff : sh;
   assign left   = differ ? (((sw - cwc_ff) >> 1) & ~nbcs_pkg::SIZE_W'(1)) : '0;
   assign top    = differ ? (((sh - chc_ff) >> 1) & ~nbcs_pkg::SIZE_W'(1)) : '0;

   // operands for each division of the sequence
   always_comb begin
      numer = '0;
      denom = nbcs_pkg::DVS_W'(nbcs_pkg::PCT);
      unique case (step_ff)
         3'd0: begin
            numer = nbcs_pkg::DIV_W'(sw) * nbcs_pkg::DIV_W'(nbcs_pkg::PCT);
            denom = nbcs_pkg::DVS_W'(sh);
         end
         3'd1: begin
            numer = nbcs_pkg::DIV_W'(dw) * nbcs_pkg::DIV_W'(nbcs_pkg::PCT);
            denom = nbcs_pkg::DVS_W'(dh);
         end
         3'd2: begin
            numer = nbcs_pkg::DIV_W'(sw) * nbcs_pkg::DIV_W'(nbcs_pkg::PCT);
            denom = nbcs_pkg::DVS_W'(dw);
         end
         3'd3: begin
            numer = nbcs_pkg::DIV_W'(sh) * nbcs_pkg::DIV_W'(nbcs_pkg::PCT);
            denom = nbcs_pkg::DVS_W'(dh);
         end
         3'd4: numer = nbcs_pkg::DIV_W'(ratio) * nbcs_pkg::DIV_W'(dw);
         3'd5: numer = nbcs_pkg::DIV_W'(ratio) * nbcs_pkg::DIV_W'(dh);
         3'd6: begin
            numer = nbcs_pkg::DIV_W'(cw) << nbcs_pkg::FRAC_W;
            denom = nbcs_pkg::DVS_W'(dw);
         end
         3'd7: begin
            numer = nbcs_pkg::DIV_W'(chh) << nbcs_pkg::FRAC_W;
            denom = nbcs_pkg::DVS_W'(dh);
         end
      endcase
   end

   nbcs_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (state_ff == G_LAUNCH),
      .numer (numer),
      .denom (denom),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= nbcs_pkg::CFG_W'(256);
         src_h_ff <= nbcs_pkg::CFG_W'(256);
         dst_w_ff <= nbcs_pkg::CFG_W'(256);
         dst_h_ff <= nbcs_pkg::CFG_W'(256);
         state_ff <= G_LAUNCH;
         step_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            nbcs_pkg::REG_SRC_WIDTH:  src_w_ff <= csr_wdata;
            nbcs_pkg::REG_SRC_HEIGHT: src_h_ff <= csr_wdata;
            nbcs_pkg::REG_DST_WIDTH:  dst_w_ff <= csr_wdata;
            nbcs_pkg::REG_DST_HEIGHT: dst_h_ff <= csr_wdata;
         endcase
         state_ff <= G_LAUNCH;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            G_IDLE:   state_ff <= G_IDLE;
            G_LAUNCH: state_ff <= G_WAIT;
            G_WAIT: begin
               if (div_done) begin
                  if (step_ff == 3'd7) begin
                     state_ff <= G_BASE;
                  end else begin
                     step_ff  <= step_ff + 3'd1;
                     state_ff <= G_LAUNCH;
                  end
               end
            end
            G_BASE:   state_ff <= G_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == G_WAIT && div_done) begin
         unique case (step_ff)
            3'd0: qs_ff   <= nbcs_pkg::RATIO_W'(quot);
            3'd1: qd_ff   <= nbcs_pkg::RATIO_W'(quot);
            3'd2: rw_ff   <= nbcs_pkg::RATIO_W'(quot);
            3'd3: rh_ff   <= nbcs_pkg::RATIO_W'(quot);
            3'd4: cwc_ff  <= nbcs_pkg::SIZE_W'(quot);
            3'd5: chc_ff  <= nbcs_pkg::SIZE_W'(quot);
            3'd6: invx_ff <= nbcs_pkg::INV_W'(quot) + nbcs_pkg::INV_W'(1);
            3'd7: invy_ff <= nbcs_pkg::INV_W'(quot) + nbcs_pkg::INV_W'(1);
         endcase
      end
      if (state_ff == G_BASE) begin
         cbase_ff <= nbcs_pkg::ADDR_W'(sw) * nbcs_pkg::ADDR_W'(sh)
                   + ((nbcs_pkg::ADDR_W'(top) * nbcs_pkg::ADDR_W'(sw)) >> 1)
                   + nbcs_pkg::ADDR_W'(left);
      end
   end

   assign geom.sw    = sw;
   assign geom.sh    = sh;
   assign geom.left  = left;
   assign geom.top   = top;
   assign geom.invx  = invx_ff;
   assign geom.invy  = invy_ff;
   assign geom.cbase = cbase_ff;
   assign geom.ready = (state_ff == G_IDLE) && !csr_write_en;

endmodule

FILE: rtl/nbcs_fstore.sv
// Single-port frame store with registered read data.
// Depends on nbcs_pkg for depth and address width.
module nbcs_fstore (
   input  logic                         clock,
   input  logic                         we,
   input  logic                         re,
   input  logic [nbcs_pkg::MEM_AW-1:0]  addr,
   input  logic [nbcs_pkg::PIX_W-1:0]   wdata,
   output logic [nbcs_pkg::PIX_W-1:0]   rdata
);

   logic [nbcs_pkg::PIX_W-1:0] mem [nbcs_pkg::FRAME_BYTES];
   logic [nbcs_pkg::PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/nbcs_blend.sv
// Two-stage bilinear blend of a 2x2 quad: horizontal pass, then vertical pass.
// Depends on nbcs_pkg for widths.
module nbcs_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [1:0]                          in_tag,
   input  logic [3:0][nbcs_pkg::PIX_W-1:0]     pix,
   input  logic [nbcs_pkg::FRAC_W-1:0]         fx,
   input  logic [nbcs_pkg::FRAC_W-1:0]         fy,
   output logic                                out_valid,
   output logic [1:0]                          out_tag,
   output logic [nbcs_pkg::PIX_W-1:0]          out_value
);

   localparam int PW = nbcs_pkg::PIX_W + nbcs_pkg::FRAC_W + 1;

   logic [nbcs_pkg::FRAC_W-1:0] wx, wy;
   logic [PW-1:0]               s0, s1, sv;
   logic                        a_valid_ff, b_valid_ff;
   logic [1:0]                  a_tag_ff, b_tag_ff;
   logic [nbcs_pkg::PIX_W-1:0]  r0_ff, r1_ff, val_ff;
   logic [nbcs_pkg::FRAC_W-1:0] fy_ff;

   assign wx = ~fx;
   assign wy = ~fy_ff;
   assign s0 = PW'(pix[0]) * PW'(wx) + PW'(pix[1]) * PW'(fx);
   assign s1 = PW'(pix[2]) * PW'(wx) + PW'(pix[3]) * PW'(fx);
   assign sv = PW'(r0_ff) * PW'(wy) + PW'(r1_ff) * PW'(fy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff    <= s0[nbcs_pkg::FRAC_W +: nbcs_pkg::PIX_W];
      r1_ff    <= s1[nbcs_pkg::FRAC_W +: nbcs_pkg::PIX_W];
      fy_ff    <= fy;
      a_tag_ff <= in_tag;
      val_ff   <= sv[nbcs_pkg::FRAC_W +: nbcs_pkg::PIX_W];
      b_tag_ff <= a_tag_ff;
   end

   assign out_valid = b_valid_ff;
   assign out_tag   = b_tag_ff;
   assign out_value = val_ff;

endmodule

FILE: rtl/nv12_bilinear_crop_scaler.sv
// NV12 bilinear crop scaler, top level. Load requests (action 0) write one source byte with
// one frame-store access; a luma sample takes four frame-store reads and a chroma pair eight,
// all through the single port of the frame store; the engine takes a new request only as it
// makes the last access of the one before. A result is registered on rsp_* and is strobed by
// rsp_valid for exactly one cycle; the receiver cannot stall, so take it then. After reset and
// after every csr write the crop and step geometry is recomputed with a serial divider (eight
// divisions), and busy stays high until it is done. Write configuration only while no request
// is in flight.
// Depends on nbcs_pkg, nbcs_geom, nbcs_fstore and nbcs_blend.
module nv12_bilinear_crop_scaler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [nbcs_pkg::LOAD_AW-1:0]      req_load_addr,
   input  logic [nbcs_pkg::PIX_W-1:0]        req_load_byte,
   input  logic [nbcs_pkg::COORD_W-1:0]      req_out_x,
   input  logic [nbcs_pkg::COORD_W-1:0]      req_out_y,
   output logic                              rsp_valid,
   output logic [nbcs_pkg::PIX_W-1:0]        rsp_sample_first,
   output logic [nbcs_pkg::PIX_W-1:0]        rsp_sample_second,
   input  logic                              csr_write_en,
   input  logic [nbcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nbcs_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int AW = nbcs_pkg::ADDR_W;
   localparam int SW = nbcs_pkg::SIZE_W;

   nbcs_pkg::geom_type geom;

   // stage 1: request register
   logic                           s1_valid_ff;
   logic [1:0]                     s1_act_ff;
   logic [nbcs_pkg::LOAD_AW-1:0]   s1_laddr_ff;
   logic [nbcs_pkg::PIX_W-1:0]     s1_lbyte_ff;
   logic [nbcs_pkg::COORD_W-1:0]   s1_x_ff, s1_y_ff;
   // stage 2: scaled positions
   logic                           s2_valid_ff;
   logic [1:0]                     s2_act_ff;
   logic [nbcs_pkg::LOAD_AW-1:0]   s2_laddr_ff;
   logic [nbcs_pkg::PIX_W-1:0]     s2_lbyte_ff;
   logic [nbcs_pkg::PX_W-1:0]      s2_px_ff, s2_py_ff;
   // access engine: owns the frame-store port
   logic                           eng_valid_ff;
   logic [1:0]                     eng_act_ff;
   logic [AW-1:0]                  eng_addr_ff;
   logic [nbcs_pkg::PIX_W-1:0]     eng_byte_ff;
   logic [nbcs_pkg::FRAC_W-1:0]    eng_fx_ff, eng_fy_ff;
   logic [2:0]                     eng_idx_ff;
   // read return
   logic                           rp_valid_ff, rp_oob_ff;
   logic [1:0]                     rp_idx_ff, rp_tag_ff;
   logic [nbcs_pkg::FRAC_W-1:0]    rp_fx_ff, rp_fy_ff;
   logic [3:0][nbcs_pkg::PIX_W-1:0] quad_ff;
   logic                           q_valid_ff;
   logic [1:0]                     q_tag_ff;
   logic [nbcs_pkg::FRAC_W-1:0]    q_fx_ff, q_fy_ff;
   // result
   logic                           rsp_valid_ff;
   logic [nbcs_pkg::PIX_W-1:0]     first_ff, second_ff, u_hold_ff;

   logic accept, s1_adv, s2_adv, eng_free, eng_last;
   logic s2_luma;
   logic [SW-1:0]  size_x, size_y, bx, by;
   logic [SW:0]    row;
   logic [AW-1:0]  a0, rd_addr, col_step;
   logic           mem_we, mem_re, rd_oob;
   logic [nbcs_pkg::PIX_W-1:0] mem_rdata;
   logic           bl_valid;
   logic [1:0]     bl_tag;
   logic [nbcs_pkg::PIX_W-1:0] bl_value;

   nbcs_geom u_geom (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .geom         (geom)
   );

   // Handshake and pipeline advance. The engine frees on the cycle of its last access.
   assign eng_last = eng_valid_ff && ((eng_act_ff == nbcs_pkg::ACT_LOAD)
                     || (eng_act_ff == nbcs_pkg::ACT_LUMA && eng_idx_ff == 3'd3)
                     || (eng_idx_ff == 3'd7));
   assign eng_free = !eng_valid_ff || eng_last;
   assign s2_adv   = s2_valid_ff && eng_free;
   assign s1_adv   = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign busy     = !geom.ready || (s1_valid_ff && !s1_adv);
   assign accept   = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         eng_valid_ff <= 1'b0;
         eng_idx_ff   <= '0;
         rp_valid_ff  <= 1'b0;
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the unused action at the door
         if (accept) begin
            s1_valid_ff <= (req_action != nbcs_pkg::ACT_NONE);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            eng_valid_ff <= 1'b1;
            eng_idx_ff   <= '0;
         end else begin
            if (eng_last) begin
               eng_valid_ff <= 1'b0;
            end
            eng_idx_ff <= eng_idx_ff + 3'd1;
         end
         rp_valid_ff  <= eng_valid_ff && (eng_act_ff != nbcs_pkg::ACT_LOAD);
         q_valid_ff   <= rp_valid_ff && (rp_idx_ff == 2'd3);
         rsp_valid_ff <= bl_valid && (bl_tag != nbcs_pkg::TAG_U);
      end
   end

   // Stage 1 -> 2: scale destination coordinates to 16.16 source positions.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff   <= req_action;
         s1_laddr_ff <= req_load_addr;
         s1_lbyte_ff <= req_load_byte;
         s1_x_ff     <= req_out_x;
         s1_y_ff     <= req_out_y;
      end
      if (s1_adv) begin
         s2_act_ff   <= s1_act_ff;
         s2_laddr_ff <= s1_laddr_ff;
         s2_lbyte_ff <= s1_lbyte_ff;
         s2_px_ff    <= nbcs_pkg::PX_W'(s1_x_ff) * nbcs_pkg::PX_W'(geom.invx);
         s2_py_ff    <= nbcs_pkg::PX_W'(s1_y_ff) * nbcs_pkg::PX_W'(geom.invy);
      end
   end

   // Stage 2 -> engine: clamp the base and form the top-left address of the quad.
   // Both planes step one source row per lower-row access (chroma rows are sw bytes).
   always_comb begin
      s2_luma = (s2_act_ff == nbcs_pkg::ACT_LUMA);
      size_x  = s2_luma ? geom.sw : (geom.sw >> 1);
      size_y  = s2_luma ? geom.sh : (geom.sh >> 1);
      bx      = nbcs_pkg::clamp_base(s2_px_ff[nbcs_pkg::PX_W-1:nbcs_pkg::FRAC_W], size_x);
      by      = nbcs_pkg::clamp_base(s2_py_ff[nbcs_pkg::PX_W-1:nbcs_pkg::FRAC_W], size_y);
      row     = s2_luma ? ((SW+1)'(geom.top) + (SW+1)'(by)) : (SW+1)'(by);
      a0      = AW'(row) * AW'(geom.sw)
              + (s2_luma ? (AW'(geom.left) + AW'(bx)) : (geom.cbase + (AW'(bx) << 1)));
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         eng_act_ff  <= s2_act_ff;
         eng_addr_ff <= (s2_act_ff == nbcs_pkg::ACT_LOAD) ? AW'(s2_laddr_ff) : a0;
         eng_byte_ff <= s2_lbyte_ff;
         eng_fx_ff   <= s2_px_ff[nbcs_pkg::FRAC_W-1:0];
         eng_fy_ff   <= s2_py_ff[nbcs_pkg::FRAC_W-1:0];
      end
   end

   // Access address: bit 0 picks the right column, bit 1 the lower row,
   // bit 2 the V byte of an interleaved chroma pair.
   assign col_step = (eng_act_ff == nbcs_pkg::ACT_LUMA) ? AW'(1) : AW'(2);
   assign rd_addr  = eng_addr_ff + (eng_idx_ff[0] ? col_step : '0)
                   + (eng_idx_ff[1] ? AW'(geom.sw) : '0) + AW'(eng_idx_ff[2]);
   assign rd_oob   = (rd_addr >= AW'(nbcs_pkg::FRAME_BYTES));
   assign mem_we   = eng_valid_ff && (eng_act_ff == nbcs_pkg::ACT_LOAD)
                   && (eng_addr_ff < AW'(nbcs_pkg::FRAME_BYTES));
   assign mem_re   = eng_valid_ff && (eng_act_ff != nbcs_pkg::ACT_LOAD) && !rd_oob;

   nbcs_fstore u_fstore (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (nbcs_pkg::MEM_AW'(mem_we ? eng_addr_ff : rd_addr)),
      .wdata (eng_byte_ff),
      .rdata (mem_rdata)
   );

   // Read return: collect four bytes into the quad; reads past the store give zero.
   always_ff @(posedge clock) begin
      rp_idx_ff <= eng_idx_ff[1:0];
      rp_oob_ff <= rd_oob;
      rp_fx_ff  <= eng_fx_ff;
      rp_fy_ff  <= eng_fy_ff;
      rp_tag_ff <= (eng_act_ff == nbcs_pkg::ACT_LUMA) ? nbcs_pkg::TAG_LUMA
                 : (eng_idx_ff[2] ? nbcs_pkg::TAG_V : nbcs_pkg::TAG_U);
      if (rp_valid_ff) begin
         quad_ff[rp_idx_ff] <= rp_oob_ff ? '0 : mem_rdata;
      end
      if (rp_valid_ff && rp_idx_ff == 2'd3) begin
         q_tag_ff <= rp_tag_ff;
         q_fx_ff  <= rp_fx_ff;
         q_fy_ff  <= rp_fy_ff;
      end
   end

   nbcs_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid_ff),
      .in_tag    (q_tag_ff),
      .pix       (quad_ff),
      .fx        (q_fx_ff),
      .fy        (q_fy_ff),
      .out_valid (bl_valid),
      .out_tag   (bl_tag),
      .out_value (bl_value)
   );

   // Hold U until its V arrives, then present the pair.
   always_ff @(posedge clock) begin
      if (bl_valid) begin
         unique case (bl_tag)
            nbcs_pkg::TAG_LUMA: begin
               first_ff  <= bl_value;
               second_ff <= '0;
            end
            nbcs_pkg::TAG_U: u_hold_ff <= bl_value;
            nbcs_pkg::TAG_V: begin
               first_ff  <= u_hold_ff;
               second_ff <= bl_value;
            end
            default: u_hold_ff <= u_hold_ff;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_first  = first_ff;
   assign rsp_sample_second = second_ff;

   a_load_no_read: assert property (@(posedge clock) disable iff (reset)
      eng_valid_ff && eng_act_ff == nbcs_pkg::ACT_LOAD |=> !rp_valid_ff)
      else $error("frame-store write produced a read return");

   a_read_from_engine: assert property (@(posedge clock) disable iff (reset)
      rp_valid_ff |-> $past(eng_valid_ff))
      else $error("read return without an engine access");

   a_quad_contiguous: assert property (@(posedge clock) disable iff (reset)
      rp_valid_ff && rp_idx_ff != 2'd0 |-> $past(rp_valid_ff))
      else $error("quad reads not back to back");

   a_no_accept_while_computing: assert property (@(posedge clock) disable iff (reset)
      !geom.ready |-> !accept)
      else $error("request transfer during geometry update");

endmodule
